// File: rtl/core/mst_pkg.sv
`default_nettype none
package mst_pkg;

  // fixed field widths of the stream words, and the rank width
  localparam int NODE_W      = 11;
  localparam int IN_WGT_W    = 16;
  localparam int COST_W      = 26;
  localparam int RANK_W      = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

  // default sizes
  localparam int DEF_MAX_NODES   = 1024;
  localparam int DEF_MAX_EDGES   = 1024;
  localparam int DEF_WEIGHT_BITS = 16;

  // commands to the union-find unit
  typedef struct packed {
    logic init_go;
    logic join_go;
  } uf_cmd_t;

  // status back from the union-find unit
  typedef struct packed {
    logic done;
    logic joined;
  } uf_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/mst_edge_sort.sv
`default_nettype none
module mst_edge_sort
  import mst_pkg::*;
#(
  parameter int MAX_EDGES   = DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
  parameter int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  parameter int ECW = $clog2(MAX_EDGES + 1),
  parameter int EW  = 2 * NODE_W + WEIGHT_BITS
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire logic [EAW-1:0] wr_addr,
  input  wire logic [EW-1:0]  wr_data,
  input  wire logic           rd_en,
  input  wire logic [EAW-1:0] rd_addr,
  output logic      [EW-1:0]  rd_data,
  input  wire logic           sort_go,
  input  wire logic [ECW-1:0] sort_cnt,
  output logic                sort_done
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KEY  = 3'd1;
  localparam logic [2:0] S_KEYW = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  logic [EW-1:0] mem [MAX_EDGES];
  logic [EW-1:0] rq_r;

  logic [2:0]     st_r, st_nxt;
  logic [ECW-1:0] i_r, i_nxt, j_r, j_nxt, cnt_r, cnt_nxt;
  logic [EW-1:0]  key_r, key_nxt;
  logic           done_r, done_nxt;

  logic           we, re;
  logic [EAW-1:0] wa, ra;
  logic [EW-1:0]  wd;
  logic [ECW-1:0] jm1, jm2, ip1;

  assign jm1 = j_r - ECW'(1);
  assign jm2 = j_r - ECW'(2);
  assign ip1 = i_r + ECW'(1);

  // edge memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rq_r <= mem[ra];
    end
  end

  assign rd_data   = rq_r;
  assign sort_done = done_r;

  // insertion sort sequencer, ascending weight
  always_comb begin
    st_nxt   = st_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    cnt_nxt  = cnt_r;
    key_nxt  = key_r;
    done_nxt = 1'b0;
    we = wr_en;
    wa = wr_addr;
    wd = wr_data;
    re = rd_en;
    ra = rd_addr;
    case (st_r)
      S_IDLE: begin
        if (sort_go) begin
          if (sort_cnt <= ECW'(1)) begin
            done_nxt = 1'b1;
          end else begin
            cnt_nxt = sort_cnt;
            i_nxt   = ECW'(1);
            st_nxt  = S_KEY;
          end
        end
      end
      S_KEY: begin
        we = 1'b0;
        re = 1'b1;
        ra = i_r[EAW-1:0];
        st_nxt = S_KEYW;
      end
      S_KEYW: begin
        we = 1'b0;
        key_nxt = rq_r;
        j_nxt   = i_r;
        re = 1'b1;
        ra = i_r[EAW-1:0] - EAW'(1);
        st_nxt = S_CMP;
      end
      S_CMP: begin
        re = 1'b0;
        we = 1'b1;
        wa = j_r[EAW-1:0];
        if (rq_r[WEIGHT_BITS-1:0] > key_r[WEIGHT_BITS-1:0]) begin
          wd    = rq_r;
          j_nxt = jm1;
          if (jm1 == '0) begin
            st_nxt = S_PUT;
          end else begin
            re = 1'b1;
            ra = jm2[EAW-1:0];
          end
        end else begin
          wd = key_r;
          if (ip1 == cnt_r) begin
            done_nxt = 1'b1;
            st_nxt   = S_IDLE;
          end else begin
            i_nxt  = ip1;
            st_nxt = S_KEY;
          end
        end
      end
      S_PUT: begin
        re = 1'b0;
        we = 1'b1;
        wa = j_r[EAW-1:0];
        wd = key_r;
        if (ip1 == cnt_r) begin
          done_nxt = 1'b1;
          st_nxt   = S_IDLE;
        end else begin
          i_nxt  = ip1;
          st_nxt = S_KEY;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    cnt_r <= cnt_nxt;
    key_r <= key_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/core/mst_union_find.sv
`default_nettype none
module mst_union_find
  import mst_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int NIDX = $clog2(MAX_NODES),
  parameter int NCW  = $clog2(MAX_NODES + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire uf_cmd_t         cmd,
  input  wire logic [NCW-1:0]  node_n,
  input  wire logic [NIDX-1:0] x_idx,
  input  wire logic [NIDX-1:0] y_idx,
  output uf_stat_t             stat
);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_INIT = 3'd1;
  localparam logic [2:0] U_FRD  = 3'd2;
  localparam logic [2:0] U_FCHK = 3'd3;
  localparam logic [2:0] U_CCHK = 3'd4;
  localparam logic [2:0] U_RK1  = 3'd5;
  localparam logic [2:0] U_RK2  = 3'd6;
  localparam logic [2:0] U_RK3  = 3'd7;

  logic [NIDX-1:0]   parent_mem [MAX_NODES];
  logic [RANK_W-1:0] rank_mem   [MAX_NODES];
  logic [NIDX-1:0]   pq_r;
  logic [RANK_W-1:0] rq_r;

  logic [2:0]        st_r, st_nxt;
  logic [NCW-1:0]    k_r, k_nxt, n_r, n_nxt;
  logic [NIDX-1:0]   cur_r, cur_nxt, start_r, start_nxt, root_r, root_nxt;
  logic [NIDX-1:0]   y_r, y_nxt, rx_r, rx_nxt, ry_r, ry_nxt;
  logic              phase_r, phase_nxt;
  logic [RANK_W-1:0] rkx_r, rkx_nxt;
  logic              done_r, done_nxt, joined_r, joined_nxt;

  logic              pwe, pre, rwe, rre;
  logic [NIDX-1:0]   pwa, pra, pwd, rwa, rra;
  logic [RANK_W-1:0] rwd;
  logic              fin;
  logic [NIDX-1:0]   fin_root;
  logic [NCW-1:0]    kp1;

  assign kp1 = k_r + NCW'(1);

  // parent and rank memories, registered reads
  always_ff @(posedge clk) begin
    if (pwe) begin
      parent_mem[pwa] <= pwd;
    end
    if (pre) begin
      pq_r <= parent_mem[pra];
    end
    if (rwe) begin
      rank_mem[rwa] <= rwd;
    end
    if (rre) begin
      rq_r <= rank_mem[rra];
    end
  end

  assign stat.done   = done_r;
  assign stat.joined = joined_r;

  // init of the parent and rank memories; find with path compression, then union by rank
  always_comb begin
    st_nxt     = st_r;
    k_nxt      = k_r;
    n_nxt      = n_r;
    cur_nxt    = cur_r;
    start_nxt  = start_r;
    root_nxt   = root_r;
    y_nxt      = y_r;
    rx_nxt     = rx_r;
    ry_nxt     = ry_r;
    phase_nxt  = phase_r;
    rkx_nxt    = rkx_r;
    done_nxt   = 1'b0;
    joined_nxt = joined_r;
    pwe = 1'b0;
    pre = 1'b0;
    rwe = 1'b0;
    rre = 1'b0;
    pwa = cur_r;
    pra = cur_r;
    pwd = root_r;
    rwa = rx_r;
    rra = rx_r;
    rwd = '0;
    fin      = 1'b0;
    fin_root = root_r;
    case (st_r)
      U_IDLE: begin
        if (cmd.init_go) begin
          n_nxt  = node_n;
          k_nxt  = '0;
          st_nxt = U_INIT;
        end else if (cmd.join_go) begin
          cur_nxt   = x_idx;
          start_nxt = x_idx;
          y_nxt     = y_idx;
          phase_nxt = 1'b0;
          st_nxt    = U_FRD;
        end
      end
      U_INIT: begin
        pwe = 1'b1;
        pwa = k_r[NIDX-1:0];
        pwd = k_r[NIDX-1:0];
        rwe = 1'b1;
        rwa = k_r[NIDX-1:0];
        rwd = '0;
        if (kp1 >= n_r) begin
          done_nxt = 1'b1;
          st_nxt   = U_IDLE;
        end else begin
          k_nxt = kp1;
        end
      end
      U_FRD: begin
        pre = 1'b1;
        pra = cur_r;
        st_nxt = U_FCHK;
      end
      U_FCHK: begin
        if (pq_r == cur_r) begin
          root_nxt = cur_r;
          if (start_r == cur_r) begin
            fin      = 1'b1;
            fin_root = cur_r;
          end else begin
            cur_nxt = start_r;
            pre     = 1'b1;
            pra     = start_r;
            st_nxt  = U_CCHK;
          end
        end else begin
          cur_nxt = pq_r;
          pre     = 1'b1;
          pra     = pq_r;
        end
      end
      U_CCHK: begin
        pwe = 1'b1;
        pwa = cur_r;
        pwd = root_r;
        if (pq_r == root_r) begin
          fin      = 1'b1;
          fin_root = root_r;
        end else begin
          cur_nxt = pq_r;
          pre     = 1'b1;
          pra     = pq_r;
        end
      end
      U_RK1: begin
        rre = 1'b1;
        rra = rx_r;
        st_nxt = U_RK2;
      end
      U_RK2: begin
        rkx_nxt = rq_r;
        rre = 1'b1;
        rra = ry_r;
        st_nxt = U_RK3;
      end
      U_RK3: begin
        pwe = 1'b1;
        if (rkx_r < rq_r) begin
          pwa = rx_r;
          pwd = ry_r;
        end else begin
          pwa = ry_r;
          pwd = rx_r;
          if (rkx_r == rq_r && rkx_r < RANK_MAX) begin
            rwe = 1'b1;
            rwa = rx_r;
            rwd = rkx_r + RANK_W'(1);
          end
        end
        done_nxt   = 1'b1;
        joined_nxt = 1'b1;
        st_nxt     = U_IDLE;
      end
      default: begin
        st_nxt = U_IDLE;
      end
    endcase

    // a root is settled: next endpoint, the union step, or done when both roots match
    if (fin) begin
      if (!phase_r) begin
        rx_nxt    = fin_root;
        phase_nxt = 1'b1;
        cur_nxt   = y_r;
        start_nxt = y_r;
        st_nxt    = U_FRD;
      end else begin
        ry_nxt = fin_root;
        if (fin_root == rx_r) begin
          done_nxt   = 1'b1;
          joined_nxt = 1'b0;
          st_nxt     = U_IDLE;
        end else begin
          st_nxt = U_RK1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= U_IDLE;
      done_r   <= 1'b0;
      joined_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      done_r   <= done_nxt;
      joined_r <= joined_nxt;
    end
    k_r     <= k_nxt;
    n_r     <= n_nxt;
    cur_r   <= cur_nxt;
    start_r <= start_nxt;
    root_r  <= root_nxt;
    y_r     <= y_nxt;
    rx_r    <= rx_nxt;
    ry_r    <= ry_nxt;
    phase_r <= phase_nxt;
    rkx_r   <= rkx_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/core/minimum_spanning_tree_cost_core.sv
// Edge words load one per cycle while the core is in its load phase; input stalls otherwise.
// After the last word: insertion sort of the stored edges by ascending weight through the
// single edge memory, set-up of the parent and rank memories, then per edge a read-back and
// an endpoint check; an edge in range gets two find walks with path compression and a union
// by rank when it joins two trees, and an edge with an endpoint out of range is skipped.
// One graph at a time; synchronous active-low reset clears control state, not memories.
`default_nettype none
module minimum_spanning_tree_cost_core
  import mst_pkg::*;
#(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int MAX_EDGES   = DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // end_a[10:0], end_b[21:11], weight[37:22], zero fill
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tlast,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // total_cost[25:0], zero fill
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // overflow[0]
  output logic                        out_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic [NODE_W-1:0]      cfg_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready
);

  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int NIDX = $clog2(MAX_NODES);
  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int EW   = 2 * NODE_W + WEIGHT_BITS;
  localparam int SUMW = COST_W + 8;

  localparam logic [2:0] T_LOAD = 3'd0;
  localparam logic [2:0] T_SORT = 3'd1;
  localparam logic [2:0] T_INIT = 3'd2;
  localparam logic [2:0] T_SCAN = 3'd3;
  localparam logic [2:0] T_RDW  = 3'd4;
  localparam logic [2:0] T_JOIN = 3'd5;
  localparam logic [2:0] T_DONE = 3'd6;

  logic [2:0]             st_r, st_nxt;
  logic [ECW-1:0]         cnt_r, cnt_nxt, i_r, i_nxt;
  logic                   drop_r, drop_nxt;
  logic [NCW-1:0]         n_r, n_nxt, taken_r, taken_nxt;
  logic [COST_W-1:0]      cost_r, cost_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;
  logic [NIDX-1:0]        x_r, x_nxt, y_r, y_nxt;
  logic                   sort_go_r, sort_go_nxt;
  uf_cmd_t                cmd_r, cmd_nxt;
  uf_stat_t               uf_stat;
  logic                   ovalid_r, ovalid_nxt, oflow_r, oflow_nxt;
  logic [COST_W-1:0]      ocost_r, ocost_nxt;
  logic [NODE_W-1:0]      cfg_r;

  logic                   in_acc, sort_done, wr_en, rd_en;
  logic [EW-1:0]          wr_data, rd_data;
  logic [31:0]            w32, nc32, a32, b32, am1, bm1, n32;
  logic [NODE_W-1:0]      ea, eb;
  logic                   ends_ok;
  logic [SUMW-1:0]        sum;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (st_r == T_LOAD);
  assign cfg_ready = 1'b1;

  // keep the low weight bits
  assign w32     = {16'b0, in_tdata[37:22]};
  assign wr_data = {in_tdata[10:0], in_tdata[21:11], w32[WEIGHT_BITS-1:0]};
  assign wr_en   = in_acc && (cnt_r < ECW'(MAX_EDGES));

  // clamp node count into 1..MAX_NODES
  assign nc32 = {21'b0, cfg_r};

  // endpoint range check on the edge read back
  assign ea      = rd_data[EW-1 -: NODE_W];
  assign eb      = rd_data[WEIGHT_BITS + NODE_W - 1 : WEIGHT_BITS];
  assign a32     = {21'b0, ea};
  assign b32     = {21'b0, eb};
  assign am1     = a32 - 32'd1;
  assign bm1     = b32 - 32'd1;
  assign n32     = 32'(n_r);
  assign ends_ok = (a32 != 32'd0) && (a32 <= n32) && (b32 != 32'd0) && (b32 <= n32);

  // saturating cost add
  assign sum = SUMW'(cost_r) + SUMW'(w_r);

  mst_edge_sort #(
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_sort (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (cnt_r[EAW-1:0]),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (i_r[EAW-1:0]),
    .rd_data   (rd_data),
    .sort_go   (sort_go_r),
    .sort_cnt  (cnt_r),
    .sort_done (sort_done)
  );

  mst_union_find #(
    .MAX_NODES (MAX_NODES)
  ) u_uf (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd_r),
    .node_n (n_r),
    .x_idx  (x_r),
    .y_idx  (y_r),
    .stat   (uf_stat)
  );

  // phase sequencer
  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    i_nxt       = i_r;
    drop_nxt    = drop_r;
    n_nxt       = n_r;
    taken_nxt   = taken_r;
    cost_nxt    = cost_r;
    w_nxt       = w_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    sort_go_nxt = 1'b0;
    cmd_nxt     = '0;
    rd_en       = 1'b0;
    ovalid_nxt  = ovalid_r && !out_tready;
    ocost_nxt   = ocost_r;
    oflow_nxt   = oflow_r;
    case (st_r)
      T_LOAD: begin
        if (in_acc) begin
          if (wr_en) begin
            cnt_nxt = cnt_r + ECW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            if (nc32 == 32'd0) begin
              n_nxt = NCW'(1);
            end else if (nc32 > 32'(MAX_NODES)) begin
              n_nxt = NCW'(MAX_NODES);
            end else begin
              n_nxt = nc32[NCW-1:0];
            end
            sort_go_nxt = 1'b1;
            st_nxt      = T_SORT;
          end
        end
      end
      T_SORT: begin
        if (sort_done) begin
          cmd_nxt.init_go = 1'b1;
          st_nxt          = T_INIT;
        end
      end
      T_INIT: begin
        if (uf_stat.done) begin
          i_nxt     = '0;
          taken_nxt = '0;
          cost_nxt  = '0;
          st_nxt    = T_SCAN;
        end
      end
      T_SCAN: begin
        if (i_r == cnt_r || (32'(taken_r) + 32'd1) >= n32) begin
          st_nxt = T_DONE;
        end else begin
          rd_en  = 1'b1;
          st_nxt = T_RDW;
        end
      end
      T_RDW: begin
        if (ends_ok) begin
          x_nxt          = am1[NIDX-1:0];
          y_nxt          = bm1[NIDX-1:0];
          w_nxt          = rd_data[WEIGHT_BITS-1:0];
          cmd_nxt.join_go = 1'b1;
          st_nxt         = T_JOIN;
        end else begin
          i_nxt  = i_r + ECW'(1);
          st_nxt = T_SCAN;
        end
      end
      T_JOIN: begin
        if (uf_stat.done) begin
          if (uf_stat.joined) begin
            cost_nxt  = (sum > SUMW'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
            taken_nxt = taken_r + NCW'(1);
          end
          i_nxt  = i_r + ECW'(1);
          st_nxt = T_SCAN;
        end
      end
      T_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          ocost_nxt  = cost_r;
          oflow_nxt  = drop_r;
          cnt_nxt    = '0;
          drop_nxt   = 1'b0;
          st_nxt     = T_LOAD;
        end
      end
      default: begin
        st_nxt = T_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= T_LOAD;
      cnt_r     <= '0;
      drop_r    <= 1'b0;
      taken_r   <= '0;
      cost_r    <= '0;
      sort_go_r <= 1'b0;
      cmd_r     <= '0;
      ovalid_r  <= 1'b0;
      cfg_r     <= NODE_W'(1);
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      drop_r    <= drop_nxt;
      taken_r   <= taken_nxt;
      cost_r    <= cost_nxt;
      sort_go_r <= sort_go_nxt;
      cmd_r     <= cmd_nxt;
      ovalid_r  <= ovalid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
    end
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    w_r     <= w_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    ocost_r <= ocost_nxt;
    oflow_r <= oflow_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - COST_W){1'b0}}, ocost_r};
  assign out_tuser  = oflow_r;

  // edge count stays within the store
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ECW'(MAX_EDGES))
    else $error("edge count beyond store depth");

  // scan never takes a full node count of edges
  a_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == T_SCAN || st_r == T_RDW || st_r == T_JOIN) |-> (taken_r < n_r))
    else $error("taken edge count reached node count");

  // union-find completion only while waiting for it
  a_uf_done: assert property (@(posedge clk) disable iff (!rst_n)
    uf_stat.done |-> (st_r == T_INIT || st_r == T_JOIN))
    else $error("union-find done outside init or join");

  // a new result is loaded only after the previous one left
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("pending result lost");

endmodule
`default_nettype wire
